// ----- hdl/tsdr_pkg.sv -----
// Package for the thermistor sigma-delta reader: item and register types,
// register indexes, reset values and the linearisation constants.
// Depends on nothing; the reader, front end, divider and back end import it.
`default_nettype none

package tsdr_pkg;

    // Operation codes carried by an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_C       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_M         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_LIMIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CODE   = 3'd4;

    // Register reset values.
    localparam logic [15:0]        RST_WINDOW_TICKS   = 16'd8192;
    localparam logic [15:0]        RST_OFFSET_C       = 16'd32884;
    localparam logic [3:0]         RST_GAIN_M         = 4'd4;
    localparam logic [19:0]        RST_RES_LIMIT      = 20'd30000;
    localparam logic signed [31:0] RST_INVALID_CODE   = 32'sh8000_0000;

    // Linearisation constants.
    localparam logic [11:0]        RES_SCALE  = 12'd2100;
    localparam logic [5:0]         LIN_SLOPE  = 6'd54;
    localparam logic signed [31:0] LIN_OFFSET = 32'sd469350;

    // Width of the resistance dividend: a 16 bit product times 2100.
    localparam int unsigned NUM_W = 28;

    // Depth of the queue between the window counter and the arithmetic.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0]        window_ticks;
        logic [15:0]        offset_c;
        logic [3:0]         gain_m;
        logic [19:0]        res_limit;
        logic signed [31:0] invalid_code;
    } t_cfg;

    typedef struct packed {
        logic op;
        logic comparator_level;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        raw_count;
        logic signed [31:0] temperature;
        logic               temp_valid;
    } t_out_item;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_LIN,
        BK_OUT
    } t_back_state;

endpackage

`default_nettype wire

// ----- hdl/tsdr_stream_if.sv -----
// Valid/ready stream interface used for the input and result channels.
// The payload type is a parameter; no other dependencies.
`default_nettype none

interface tsdr_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/thermistor_sigma_delta_reader.sv -----
// Thermistor sigma-delta reader. Start and tick items are accepted while the queue
// has room; a tick that closes a window yields a result after the multiply, scale,
// 28-step resistance divider and linearisation steps, or without the divider when
// the voltage is not positive. Up to two finished windows queue behind a stalled
// result before input stalls. Reset is synchronous and active low: registers
// return to their defaults, counters clear, the window halts and the queue empties.
`default_nettype none

module thermistor_sigma_delta_reader #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    tsdr_stream_if.sink                              i_in,
    tsdr_stream_if.source                            o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [tsdr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tsdr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tsdr_pkg::*;

    t_cfg                     r_cfg;
    logic                     q_full;
    logic                     q_empty;
    logic                     push;
    logic                     pop;
    logic [COUNTER_WIDTH-1:0] push_count;
    logic [COUNTER_WIDTH-1:0] q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_ticks   <= RST_WINDOW_TICKS;
            r_cfg.offset_c       <= RST_OFFSET_C;
            r_cfg.gain_m         <= RST_GAIN_M;
            r_cfg.res_limit      <= RST_RES_LIMIT;
            r_cfg.invalid_code   <= RST_INVALID_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_TICKS:   r_cfg.window_ticks   <= i_cfg_data[15:0];
                CFG_OFFSET_C:       r_cfg.offset_c       <= i_cfg_data[15:0];
                CFG_GAIN_M:         r_cfg.gain_m         <= i_cfg_data[3:0];
                CFG_RES_LIMIT:      r_cfg.res_limit      <= i_cfg_data[19:0];
                CFG_INVALID_CODE:   r_cfg.invalid_code   <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    tsdr_front #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_window_ticks (r_cfg.window_ticks),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_push_count   (push_count)
    );

    tsdr_queue #(
        .WIDTH (COUNTER_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_count),
        .i_pop       (pop),
        .o_full      (q_full),
        .o_empty     (q_empty),
        .o_head      (q_head)
    );

    tsdr_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ----- hdl/tsdr_front.sv -----
// Front end: accepts start and tick items, runs the window and high-time
// counters and pushes the captured count into the queue at window end.
// Depends on tsdr_pkg and tsdr_stream_if.
`default_nettype none

module tsdr_front #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    tsdr_stream_if.sink                   i_in,
    input  wire logic [15:0]              i_window_ticks,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output logic [COUNTER_WIDTH-1:0]      o_push_count
);
    import tsdr_pkg::*;

    logic [COUNTER_WIDTH-1:0] r_window_count, n_window_count;
    logic [COUNTER_WIDTH-1:0] r_high_count, n_high_count;
    logic                     r_high_counting, n_high_counting;
    logic                     r_prev_level, n_prev_level;
    logic                     r_running, n_running;
    logic [COUNTER_WIDTH-1:0] last_count;
    logic                     accept;
    logic                     level;
    logic                     counting;
    logic [COUNTER_WIDTH-1:0] high_inc;

    // The queue is only ever short of room when a result is waiting, so
    // stalling every item on a full queue keeps the order intact.
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign level      = i_in.data.comparator_level;

    // A zero window wraps to the all-ones count.
    assign last_count = COUNTER_WIDTH'(i_window_ticks) - COUNTER_WIDTH'(1);

    always_comb begin
        if (level && !r_prev_level) begin
            counting = 1'b1;
        end else if (!level && r_prev_level) begin
            counting = 1'b0;
        end else begin
            counting = r_high_counting;
        end
        high_inc = counting ? r_high_count + COUNTER_WIDTH'(1) : r_high_count;

        n_window_count  = r_window_count;
        n_high_count    = r_high_count;
        n_high_counting = r_high_counting;
        n_prev_level    = r_prev_level;
        n_running       = r_running;
        o_push          = 1'b0;
        o_push_count    = high_inc;

        if (accept) begin
            if (i_in.data.op == OP_START) begin
                n_window_count  = '0;
                n_high_count    = '0;
                n_high_counting = 1'b0;
                n_running       = 1'b1;
            end else if (!r_running) begin
                n_prev_level = level;
            end else begin
                n_prev_level    = level;
                n_high_count    = high_inc;
                n_high_counting = counting;
                if (r_window_count == last_count) begin
                    n_running       = 1'b0;
                    n_high_counting = 1'b0;
                    o_push          = 1'b1;
                end else begin
                    n_window_count = r_window_count + COUNTER_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_count  <= '0;
            r_high_count    <= '0;
            r_high_counting <= 1'b0;
            r_prev_level    <= 1'b0;
            r_running       <= 1'b0;
        end else begin
            r_window_count  <= n_window_count;
            r_high_count    <= n_high_count;
            r_high_counting <= n_high_counting;
            r_prev_level    <= n_prev_level;
            r_running       <= n_running;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tsdr_queue.sv -----
// Short first-in first-out queue of captured counts between the front end
// and the arithmetic back end. Depends on nothing outside this file.
`default_nettype none

module tsdr_queue #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_head
);
    localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tsdr_divider.sv -----
// Restoring divider producing one quotient bit per cycle, used for the
// resistance quotient. Depends on tsdr_pkg for the dividend width.
`default_nettype none

module tsdr_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tsdr_pkg::NUM_W-1:0] i_dividend,
    input  wire logic [15:0]                i_divisor,
    output logic                            o_done,
    output logic [tsdr_pkg::NUM_W-1:0]      o_quotient
);
    import tsdr_pkg::*;

    localparam int unsigned STEP_W = $clog2(NUM_W);

    logic [16:0]       r_rem;
    logic [NUM_W-1:0]  r_quo;
    logic [15:0]       r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [16:0]       rem_shift;
    logic              take;

    assign rem_shift  = {r_rem[15:0], r_quo[NUM_W-1]};
    assign take       = (rem_shift >= {1'b0, r_div});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
            r_step <= STEP_W'(NUM_W - 1);
        end else if (r_busy) begin
            r_rem  <= take ? rem_shift - {1'b0, r_div} : rem_shift;
            r_quo  <= {r_quo[NUM_W-2:0], take};
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tsdr_back.sv -----
// Back end: pops a captured count, works out voltage, resistance and
// temperature with a single divider and holds the result for the sink.
// Depends on tsdr_pkg, tsdr_stream_if and tsdr_divider.
`default_nettype none

module tsdr_back #(
    parameter int unsigned COUNTER_WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire tsdr_pkg::t_cfg           i_cfg,
    input  wire logic                     i_q_empty,
    input  wire logic [COUNTER_WIDTH-1:0] i_q_head,
    output logic                          o_pop,
    tsdr_stream_if.source                 o_out
);
    import tsdr_pkg::*;

    localparam int unsigned PW    = COUNTER_WIDTH + 4;
    localparam int unsigned CMP_W = (PW > 16) ? PW : 16;

    t_back_state              r_state, n_state;
    logic [COUNTER_WIDTH-1:0] r_count;
    logic [PW-1:0]            r_prod;
    logic                     r_pos;
    logic [15:0]              r_volt;
    logic [NUM_W-1:0]         r_num;
    t_out_item                r_out;
    logic                     div_start;
    logic                     div_done;
    logic [NUM_W-1:0]         quotient;
    logic                     pos;
    logic [25:0]              slope_prod;
    logic                     res_ok;

    tsdr_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_num),
        .i_divisor  (r_volt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Voltage is positive exactly when gain times count stays below the
    // offset, and then the product fits in 16 bits.
    assign pos        = (CMP_W'(r_prod) < CMP_W'(i_cfg.offset_c));
    assign slope_prod = 26'(quotient[19:0]) * 26'(LIN_SLOPE);
    assign res_ok     = r_pos && (quotient <= NUM_W'(i_cfg.res_limit));

    assign o_out.data = r_out;

    always_comb begin
        n_state     = r_state;
        o_pop       = 1'b0;
        div_start   = 1'b0;
        o_out.valid = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                n_state = BK_SCALE;
            end
            BK_SCALE: begin
                n_state = pos ? BK_DIV_START : BK_LIN;
            end
            BK_DIV_START: begin
                div_start = 1'b1;
                n_state   = BK_DIV_WAIT;
            end
            BK_DIV_WAIT: begin
                if (div_done) begin
                    n_state = BK_LIN;
                end
            end
            BK_LIN: begin
                n_state = BK_OUT;
            end
            BK_OUT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_IDLE) begin
            r_count <= i_q_head;
        end
        if (r_state == BK_MUL) begin
            r_prod <= PW'(i_cfg.gain_m) * PW'(r_count);
        end
        if (r_state == BK_SCALE) begin
            r_pos  <= pos;
            r_volt <= i_cfg.offset_c - 16'(r_prod);
            r_num  <= NUM_W'(16'(r_prod)) * NUM_W'(RES_SCALE);
        end
        if (r_state == BK_LIN) begin
            r_out.raw_count   <= 16'(r_count);
            r_out.temp_valid  <= res_ok;
            r_out.temperature <= res_ok ? LIN_OFFSET - signed'(32'(slope_prod))
                                        : i_cfg.invalid_code;
        end
    end

endmodule

`default_nettype wire
